// ===== rtl/core/fat12_pkg.sv =====
// types and constants shared by the fat12 cluster chain walker
// depends on nothing; used by the walker top and the bench
package fat12_pkg;

  // request codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // walk status codes
  localparam logic [1:0] WS_MORE = 2'd0;
  localparam logic [1:0] WS_LAST = 2'd1;
  localparam logic [1:0] WS_NONE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] DATA_BASE_RST    = 16'd33;
  localparam logic [12:0] SECTOR_BYTES_RST = 13'd512;

  // fat entries at or above this end a chain
  localparam logic [11:0] END_MARK   = 12'hFF0;
  localparam logic [11:0] FAT_EOC    = 12'hFFF;
  localparam logic [7:0]  LO_NIBBLE  = 8'h0F;
  localparam logic [7:0]  HI_NIBBLE  = 8'hF0;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  fat_byte;
    logic        restart_load;
    logic [11:0] first_cluster;
    logic [31:0] file_size;
  } req_t;

  typedef struct packed {
    logic [15:0] sector_number;
    logic [1:0]  walk_status;
  } rsp_t;

endpackage

// ===== rtl/core/fat12_chan_if.sv =====
// valid/ready channel carrying one word of a given payload type
// payload types come from fat12_pkg
interface fat12_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/fat12_fat_ram.sv =====
// single-port-write, single-port-read fat table memory, registered read
// no package dependency
module fat12_fat_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [11:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [11:0]   rdata_o
);

  logic [11:0] mem_q [DEPTH];
  logic [11:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fat12_cluster_chain_walker_top.sv =====
// fat12 cluster chain walker: unpacks fat bytes into a table, then walks chains
// load words: one per cycle while idle, no result. start/step words: each moves the
// sequencer to look, which registers the result once the output register is free;
// look waits on the registered fat memory read; no word is taken until idle again
// reset: control, position and config registers cleared to defaults; the fat
// memory is not cleared and holds garbage until loaded
module fat12_cluster_chain_walker_top #(
  parameter int unsigned FAT_ENTRIES = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  fat12_chan_if.sink                           req_i,
  fat12_chan_if.source                         rsp_o,
  input  logic                                 cfg_we_i,
  input  logic [fat12_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fat12_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned FAT_AW = $clog2(FAT_ENTRIES);

  // sequencer: idle takes words, look consumes the fat read data
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  fat12_pkg::req_t req;
  logic            req_acc;
  logic            state_q, state_d;

  // config registers
  logic [15:0] data_base_q;
  logic [12:0] sector_bytes_q;

  // unpacker state
  logic [1:0]  load_phase_q, load_phase_d;
  logic [7:0]  held_first_q, held_first_d;
  logic [3:0]  held_nib_q, held_nib_d;
  logic [10:0] pair_q, pair_d;

  // walk state
  logic [11:0] cur_q, cur_d;
  logic [31:0] bytes_q, bytes_d;
  logic        chain_q, chain_d;
  logic        no_sector_q, no_sector_d;   // pending word answers status none
  logic        in_range_q, in_range_d;     // pending cluster lies inside the table

  // output register
  logic            out_valid_q, out_valid_d;
  fat12_pkg::rsp_t out_q, out_d;

  // memory ports
  logic              ram_we, ram_re;
  logic [11:0]       wr_idx, wr_data, rd_idx, ram_rdata;

  // load path helpers
  logic [1:0]  phase_eff;
  logic [10:0] pair_eff;
  logic [7:0]  mid_lo, mid_hi;

  // look path helpers
  logic        slot_free;
  logic [11:0] next_cl;
  logic [31:0] sb_ext, remain;
  logic        last;

  assign req       = req_i.payload;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc   = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // config writes are for the user to make only while idle; the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_base_q    <= fat12_pkg::DATA_BASE_RST;
      sector_bytes_q <= fat12_pkg::SECTOR_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fat12_pkg::CFG_DATA_BASE:    data_base_q    <= cfg_data_i;
        fat12_pkg::CFG_SECTOR_BYTES: sector_bytes_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // load path: restart mark resets the group position before the byte is used
  assign phase_eff = req.restart_load ? 2'd0 : load_phase_q;
  assign pair_eff  = req.restart_load ? 11'd0 : pair_q;
  assign mid_lo    = req.fat_byte & fat12_pkg::LO_NIBBLE;
  assign mid_hi    = req.fat_byte & fat12_pkg::HI_NIBBLE;

  always_comb begin
    load_phase_d = load_phase_q;
    held_first_d = held_first_q;
    held_nib_d   = held_nib_q;
    pair_d       = pair_q;
    ram_we       = 1'b0;
    wr_idx       = {pair_eff, 1'b0};
    wr_data      = '0;
    if (req_acc && req.func == fat12_pkg::FUNC_LOAD) begin
      pair_d = pair_eff;
      unique case (phase_eff)
        2'd0: begin
          held_first_d = req.fat_byte;
          load_phase_d = 2'd1;
        end
        2'd1: begin
          // even entry: low byte plus low nibble of the middle byte
          wr_idx       = {pair_eff, 1'b0};
          wr_data      = {mid_lo[3:0], held_first_q};
          ram_we       = 1'b1;
          held_nib_d   = mid_hi[7:4];
          load_phase_d = 2'd2;
        end
        default: begin
          // odd entry: high nibble of the middle byte plus the last byte
          wr_idx       = {pair_eff, 1'b1};
          wr_data      = {req.fat_byte, held_nib_q};
          ram_we       = 1'b1;
          pair_d       = pair_eff + 11'd1;
          load_phase_d = 2'd0;
        end
      endcase
      // entries past the table are dropped
      if ({1'b0, wr_idx} >= 13'(FAT_ENTRIES)) begin
        ram_we = 1'b0;
      end
    end
  end

  // a read is only issued on a walk accept, a write only on a load accept, so
  // the two never share a cycle and a write always lands before a later read
  assign rd_idx = (req.func == fat12_pkg::FUNC_START) ? req.first_cluster : cur_q;
  assign ram_re = req_acc && (req.func == fat12_pkg::FUNC_START ||
                              req.func == fat12_pkg::FUNC_STEP);

  fat12_fat_ram #(
    .DEPTH (FAT_ENTRIES),
    .AW    (FAT_AW)
  ) u_fat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx[FAT_AW-1:0]),
    .wdata_i (wr_data),
    .re_i    (ram_re),
    .raddr_i (rd_idx[FAT_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // look path: next link, byte count and status from the fat read data
  assign next_cl = in_range_q ? ram_rdata : fat12_pkg::FAT_EOC;
  assign sb_ext  = {19'd0, sector_bytes_q};
  assign remain  = (bytes_q > sb_ext) ? (bytes_q - sb_ext) : 32'd0;
  assign last    = (next_cl >= fat12_pkg::END_MARK) || (remain == 32'd0);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    bytes_d     = bytes_q;
    chain_d     = chain_q;
    no_sector_d = no_sector_q;
    in_range_d  = in_range_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          unique case (req.func)
            fat12_pkg::FUNC_START: begin
              // a new start drops any chain in progress
              chain_d    = 1'b0;
              cur_d      = req.first_cluster;
              in_range_d = {1'b0, req.first_cluster} < 13'(FAT_ENTRIES);
              state_d    = ST_LOOK;
              if (req.first_cluster >= fat12_pkg::END_MARK || req.file_size == 32'd0) begin
                no_sector_d = 1'b1;
              end else begin
                no_sector_d = 1'b0;
                bytes_d     = req.file_size;
              end
            end
            fat12_pkg::FUNC_STEP: begin
              no_sector_d = !chain_q;
              in_range_d  = {1'b0, cur_q} < 13'(FAT_ENTRIES);
              state_d     = ST_LOOK;
            end
            default: ;
          endcase
        end
      end
      default: begin
        // wait here, read data held, until the output register is free
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (no_sector_q) begin
            out_d.sector_number = 16'd0;
            out_d.walk_status   = fat12_pkg::WS_NONE;
          end else begin
            out_d.sector_number = data_base_q + 16'(cur_q) - 16'd2;
            bytes_d             = remain;
            if (last) begin
              out_d.walk_status = fat12_pkg::WS_LAST;
              chain_d           = 1'b0;
            end else begin
              out_d.walk_status = fat12_pkg::WS_MORE;
              chain_d           = 1'b1;
              cur_d             = next_cl;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      load_phase_q <= 2'd0;
      held_first_q <= 8'd0;
      held_nib_q   <= 4'd0;
      pair_q       <= 11'd0;
      cur_q        <= 12'd0;
      bytes_q      <= 32'd0;
      chain_q      <= 1'b0;
      no_sector_q  <= 1'b0;
      in_range_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      load_phase_q <= load_phase_d;
      held_first_q <= held_first_d;
      held_nib_q   <= held_nib_d;
      pair_q       <= pair_d;
      cur_q        <= cur_d;
      bytes_q      <= bytes_d;
      chain_q      <= chain_d;
      no_sector_q  <= no_sector_d;
      in_range_q   <= in_range_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload of the output register needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // memory never sees a read and a write in one cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("fat memory read and write in the same cycle");

  // a new result only follows a look cycle
  a_rsp_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_LOOK))
    else $error("result appeared without a fat lookup");

  // an active chain never sits on an end-of-chain cluster
  a_chain_cluster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_q |-> (cur_q < fat12_pkg::END_MARK))
    else $error("active chain holds an end-of-chain cluster");

  // a no-sector answer always carries sector zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.walk_status == fat12_pkg::WS_NONE) |->
      (out_q.sector_number == 16'd0))
    else $error("no-sector result with nonzero sector");

endmodule

// ===== bench/tb_fat12_cluster_chain_walker_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for fat12_cluster_chain_walker_top: fat loading and chain walks
// checked word by word against a built-in model of the walker
// depends on fat12_pkg, fat12_chan_if and the walker rtl
module tb_fat12_cluster_chain_walker_top;

  localparam int unsigned SETTLE_CYCLES = 8;       // latency margin after the last result
  localparam int unsigned DRAIN_LIMIT   = 100000;  // cycles allowed for the block to empty
  localparam int unsigned HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int unsigned PRINT_MAX     = 40;      // mismatch lines printed, all are counted
  localparam int unsigned PHASE_WORDS   = 400;
  localparam int unsigned HEAD_PAIRS    = 128;     // head of the table, three bytes per pair
  localparam int unsigned HEAD_ENTRIES  = 256;     // every walked cluster and link lies here
  localparam int unsigned LIMIT_NS      = 2000000;

  // position inside a packed three-byte group
  typedef enum logic [1:0] {GRP_B0, GRP_B1, GRP_B2} grp_e;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we;
  logic [fat12_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [fat12_pkg::CFG_DATA_W-1:0] cfg_data;

  fat12_chan_if #(.payload_t(fat12_pkg::req_t)) req_if ();
  fat12_chan_if #(.payload_t(fat12_pkg::rsp_t)) rsp_if ();

  fat12_cluster_chain_walker_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // words waiting to be offered, and sectors the block still owes us
  fat12_pkg::req_t pending [$];
  fat12_pkg::rsp_t sector_due [$];

  // model copy of the walker: fat contents, loader position, chain position, registers
  logic [11:0] fat_mirror [4096];
  logic [15:0] base_reg   = fat12_pkg::DATA_BASE_RST;
  logic [12:0] sb_reg     = fat12_pkg::SECTOR_BYTES_RST;
  grp_e        grp_pos    = GRP_B0;
  logic [7:0]  held_lo    = '0;
  logic [3:0]  held_nib   = '0;
  logic [10:0] ld_pair    = '0;
  logic [11:0] cur_cluster = '0;
  logic [31:0] bytes_left = '0;
  logic        chain_live = 1'b0;

  // idling knobs, per phase
  int unsigned send_pct_of [5] = '{0, 0, 84, 0, 16};
  int unsigned stall_pct_of [5] = '{0, 0, 0, 84, 16};
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // receiver hold-off, kicked by the sequencer and counted down on its own
  logic        hold_kick = 1'b0;
  int unsigned hold_left;

  int unsigned err_cnt = 0;
  int unsigned words_in = 0;
  int unsigned loads_in = 0;
  int unsigned n_more = 0;
  int unsigned n_last = 0;
  int unsigned n_none = 0;
  int unsigned n_cfg = 0;
  fat12_pkg::rsp_t want;

  task automatic report_mismatch(input string what);
    if (err_cnt < PRINT_MAX) $display("[%0t] mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // queue helpers
  function automatic void enqueue_word(input fat12_pkg::req_t r);
    pending = {pending, r};
  endfunction

  function automatic void owe_sector(input fat12_pkg::rsp_t r);
    sector_due = {sector_due, r};
  endfunction

  // ---------------------------------------------------------------------------
  // model of the walker
  // ---------------------------------------------------------------------------

  // sector of cluster c, then advance along the chain or close it
  function automatic fat12_pkg::rsp_t next_sector(input logic [11:0] c);
    fat12_pkg::rsp_t r;
    logic [11:0]     link;
    link = fat_mirror[c];
    // cluster 0 and 1 land below the data area; the 16-bit sum wraps around 2^16
    r.sector_number = base_reg + 16'(c) - 16'd2;
    // the count saturates at zero; a zero sector size never counts anything
    if (bytes_left > 32'(sb_reg)) bytes_left = bytes_left - 32'(sb_reg);
    else bytes_left = '0;
    if (link >= fat12_pkg::END_MARK || bytes_left == 0) begin
      chain_live = 1'b0;
      r.walk_status = fat12_pkg::WS_LAST;
    end else begin
      cur_cluster = link;
      chain_live = 1'b1;
      r.walk_status = fat12_pkg::WS_MORE;
    end
    return r;
  endfunction

  // apply one accepted word to the model and queue the sector it owes
  function automatic void predict_sector(input fat12_pkg::req_t r);
    fat12_pkg::rsp_t none_rsp;
    none_rsp.sector_number = '0;
    none_rsp.walk_status   = fat12_pkg::WS_NONE;
    case (r.func)
      fat12_pkg::FUNC_LOAD: begin
        // the restart mark drops any partial group and rewinds to entry 0
        if (r.restart_load) begin
          grp_pos = GRP_B0;
          ld_pair = '0;
        end
        case (grp_pos)
          GRP_B0: begin
            held_lo = r.fat_byte;
            grp_pos = GRP_B1;
          end
          GRP_B1: begin
            fat_mirror[{ld_pair, 1'b0}] = {r.fat_byte[3:0], held_lo};
            held_nib = r.fat_byte[7:4];
            grp_pos = GRP_B2;
          end
          default: begin
            fat_mirror[{ld_pair, 1'b1}] = {r.fat_byte, held_nib};
            ld_pair = ld_pair + 11'd1;  // wraps after the last pair
            grp_pos = GRP_B0;
          end
        endcase
        loads_in++;
      end
      fat12_pkg::FUNC_START: begin
        // a new start always drops the chain in progress
        chain_live = 1'b0;
        if (r.first_cluster >= fat12_pkg::END_MARK || r.file_size == 0) begin
          owe_sector(none_rsp);
        end else begin
          bytes_left = r.file_size;
          owe_sector(next_sector(r.first_cluster));
        end
      end
      fat12_pkg::FUNC_STEP: begin
        if (!chain_live) owe_sector(none_rsp);
        else owe_sector(next_sector(cur_cluster));
      end
      default: ;  // unused code, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  // every field random; callers overwrite the fields their code uses
  function automatic fat12_pkg::req_t rand_req(input logic [1:0] f);
    fat12_pkg::req_t r;
    r.func          = f;
    r.fat_byte      = 8'($urandom_range(0, 255));
    r.restart_load  = 1'($urandom_range(0, 1));
    r.first_cluster = 12'($urandom_range(0, 4095));
    r.file_size     = $urandom();
    return r;
  endfunction

  task automatic push_load(input logic [7:0] b, input logic rs);
    fat12_pkg::req_t r;
    r = rand_req(fat12_pkg::FUNC_LOAD);
    r.fat_byte = b;
    r.restart_load = rs;
    enqueue_word(r);
  endtask

  // two 12-bit entries packed into three bytes
  task automatic push_pair(input logic [11:0] e0, input logic [11:0] e1, input logic rs);
    push_load(e0[7:0], rs);
    push_load({e1[3:0], e0[11:8]}, 1'b0);
    push_load(e1[11:4], 1'b0);
  endtask

  task automatic push_start(input logic [11:0] c, input logic [31:0] s);
    fat12_pkg::req_t r;
    r = rand_req(fat12_pkg::FUNC_START);
    r.first_cluster = c;
    r.file_size = s;
    enqueue_word(r);
  endtask

  task automatic push_step();
    enqueue_word(rand_req(fat12_pkg::FUNC_STEP));
  endtask

  // fat contents: plenty of end marks so chains stay short, links stay in the head
  function automatic logic [11:0] fat_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 12'($urandom_range(12'hFF0, 12'hFFF));
    if (r < 30) return 12'($urandom_range(0, 1));
    if (r < 55) return 12'($urandom_range(0, 47));
    return 12'($urandom_range(2, HEAD_ENTRIES - 1));
  endfunction

  function automatic logic [11:0] rand_cluster();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 12'($urandom_range(12'hFF0, 12'hFFF));
    if (r < 12) return 12'($urandom_range(0, 1));
    if (r < 40) return 12'($urandom_range(0, 47));
    return 12'($urandom_range(2, HEAD_ENTRIES - 1));
  endfunction

  // mostly sizes a few sectors long so both ends of a chain show up
  function automatic logic [31:0] rand_size();
    int unsigned r;
    int unsigned unit;
    r = $urandom_range(99);
    unit = (sb_reg == 0) ? 512 : sb_reg;
    if (r < 4) return 32'd0;
    if (r < 8) return 32'hFFFF_FFFF;
    if (r < 20) return $urandom();
    return 32'($urandom_range(1, 6 * unit));
  endfunction

  // mostly start-and-step walks, then fat rewrites, cut groups and noise
  task automatic fill_random(input int unsigned n);
    int unsigned made;
    int unsigned kind;
    int unsigned cnt;
    logic [11:0] e0;
    logic [11:0] e1;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        push_start(rand_cluster(), rand_size());
        cnt = $urandom_range(0, 7);
        repeat (cnt) push_step();
        made += cnt + 1;
      end else if (kind < 70) begin
        // rewrite the head of the table from entry 0
        cnt = $urandom_range(1, 24);
        for (int i = 0; i < cnt; i++) push_pair(fat_value(), fat_value(), i == 0);
        made += 3 * cnt;
      end else if (kind < 80) begin
        // leading bytes of a group only; the next restart mark cuts it short
        e0 = fat_value();
        e1 = fat_value();
        cnt = $urandom_range(1, 2);
        push_load(e0[7:0], 1'b1);
        if (cnt == 2) push_load({e1[3:0], e0[11:8]}, 1'b0);
        made += cnt;
      end else if (kind < 92) begin
        push_step();
        made += 1;
      end else begin
        enqueue_word(rand_req(fat12_pkg::FUNC_NONE));
        made += 1;
      end
    end
  endtask

  // both registers, back to back; only called while the block is idle
  task automatic set_config(input logic [15:0] base, input logic [12:0] sb);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= fat12_pkg::CFG_DATA_BASE;
    cfg_data <= base;
    @(posedge clk_i);
    cfg_idx  <= fat12_pkg::CFG_SECTOR_BYTES;
    cfg_data <= {3'b000, sb};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    base_reg = base;
    sb_reg = sb;
    n_cfg++;
  endtask

  // wait until every word is taken and every sector is back, then let loads settle
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    while ((pending.size() != 0 || req_if.valid || sector_due.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (sector_due.size() != 0)
      report_mismatch($sformatf("%0d expected sectors never arrived", sector_due.size()));
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("fat12_cluster_chain_walker_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: offers queued words, feeds the model on each accept
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_sector(req_if.payload);
        words_in++;
      end
      // slot is free: next word, or a random gap
      if (!req_if.valid || req_if.ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid   <= 1'b1;
          req_if.payload <= pending.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each result word with the oldest expected sector
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (sector_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: sector %0d status %0d",
                                    rsp_if.payload.sector_number,
                                    rsp_if.payload.walk_status));
        end else begin
          want = sector_due.pop_front();
          if (rsp_if.payload.sector_number !== want.sector_number)
            report_mismatch($sformatf("sector_number %0d, expected %0d",
                                      rsp_if.payload.sector_number, want.sector_number));
          if (rsp_if.payload.walk_status !== want.walk_status)
            report_mismatch($sformatf("walk_status %0d, expected %0d",
                                      rsp_if.payload.walk_status, want.walk_status));
          case (want.walk_status)
            fat12_pkg::WS_MORE: n_more++;
            fat12_pkg::WS_LAST: n_last++;
            default: n_none++;
          endcase
        end
      end
      // random stalls, and nothing at all while the long hold-off runs
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // long hold-off counter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: reset, directed part, then random phases
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase 0: reset values written explicitly, no idling
    set_config(fat12_pkg::DATA_BASE_RST, fat12_pkg::SECTOR_BYTES_RST);
    @(negedge clk_i);

    // the head of the table; walks and links never leave it
    for (int p = 0; p < HEAD_PAIRS; p++) push_pair(fat_value(), fat_value(), p == 0);
    // loader carries on past the head: entries no walk reaches
    push_pair(12'h123, 12'h456, 1'b0);
    // one byte of a group, then a restart mark that throws it away
    push_load(8'hA5, 1'b0);
    // chain 0 -> 2 -> 4 -> 1 -> end, with extreme bytes along the way
    push_pair(12'h002, 12'hFFF, 1'b1);
    push_pair(12'h004, 12'hFF0, 1'b0);
    push_pair(12'h001, 12'h0FF, 1'b0);

    // full chain ended by the fat, through cluster 1 below the data area
    push_start(12'h000, 32'hFFFF_FFFF);
    repeat (3) push_step();
    // step with no chain left
    push_step();
    // start on an end mark, and with an empty file
    push_start(12'hFF0, 32'd100);
    push_start(12'hFFF, 32'd5);
    push_start(12'h005, 32'd0);
    // size ends the chain: count goes past the size and stops at zero
    push_start(12'h002, 32'd1);
    push_start(12'h002, 32'd513);
    push_step();
    // new start while a walk is still going
    push_start(12'h000, 32'hFFFF_FFFF);
    push_start(12'h004, 32'd1024);
    push_step();
    // unused code with every other field at its top value
    enqueue_word(fat12_pkg::req_t'('1));

    for (int ph = 1; ph <= 4; ph++) begin
      wait_idle();
      case (ph)
        1: set_config(16'h0000, 13'd1);
        2: set_config(16'hFFFF, 13'd4096);
        3: set_config(16'($urandom()), 13'd0);  // sector size zero: only the fat ends chains
        default: set_config(16'($urandom()), 13'($urandom_range(1, 4096)));
      endcase
      @(negedge clk_i);
      send_idle_pct = send_pct_of[ph];
      stall_pct = stall_pct_of[ph];
      fill_random(PHASE_WORDS);
      if (ph == 1) begin
        // receiver goes quiet while the sender keeps pushing, so the block backs up
        @(posedge clk_i);
        hold_kick <= 1'b1;
        @(posedge clk_i);
        hold_kick <= 1'b0;
      end
    end

    wait_idle();
    $display("summary: %0d words in, %0d of them fat bytes; %0d results",
             words_in, loads_in, n_more + n_last + n_none);
    $display("summary: %0d more, %0d last, %0d none; %0d register settings, %0d-cycle hold-off",
             n_more, n_last, n_none, n_cfg, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("fat12_cluster_chain_walker_top verification clean");
    end else begin
      $display("fat12_cluster_chain_walker_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fat12_pkg.sv
rtl/core/fat12_chan_if.sv
rtl/core/fat12_fat_ram.sv
rtl/core/fat12_cluster_chain_walker_top.sv
bench/tb_fat12_cluster_chain_walker_top.sv
